// ===== design/cmoa_pkg.sv =====
// Shared types, constants and calendar helpers for the minute offset adder.
`timescale 1ns / 1ps

package cmoa_pkg;

  localparam int MinPerHour   = 60;
  localparam int HourPerDay   = 24;
  localparam int MinPerDay    = MinPerHour * HourPerDay;
  localparam int MonthPerYear = 12;
  localparam int YearSpan     = 100;
  localparam int MaxDayShift  = 23;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_WRAP    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic signed [15:0] offset_minutes;
    logic [9:0]         millis_in;
    logic [5:0]         second_in;
    logic [5:0]         minute_in;
    logic [4:0]         hour_in;
    logic [4:0]         day_in;
    logic [3:0]         month_in;
    logic [6:0]         year_in;
  } in_t;

  typedef struct packed {
    logic [4:0] pad;
    logic [9:0] millis_out;
    logic [5:0] second_out;
    logic [5:0] minute_out;
    logic [4:0] hour_out;
    logic [4:0] day_out;
    logic [3:0] month_out;
    logic [6:0] year_out;
  } out_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/calendar_minute_offset_adder.sv =====
// Top level of the calendar minute offset adder.
`timescale 1ns / 1ps
// An item is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle while m_tready is high; input and result
// registers form a two-stage pipeline with the offset arithmetic between them.
// Reset: rst is synchronous and active high; it empties both pipeline stages.
// Payload registers are not reset.

module calendar_minute_offset_adder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // year_in, month_in, day_in, hour_in, minute_in, second_in, millis_in,
  // offset_minutes, zero fill
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // year_out, month_out, day_out, hour_out, minute_out, second_out, millis_out,
  // zero fill
  output logic [47:0] m_tdata,
  // status
  output logic [1:0]  m_tuser
);

  localparam logic [16:0] Bias = 17'(cmoa_pkg::MaxDayShift * cmoa_pkg::MinPerDay);

  logic              in_valid;
  cmoa_pkg::in_t     in_q;
  logic              res_valid;
  cmoa_pkg::out_t    res_q;
  cmoa_pkg::status_t stat_q;
  logic              stage_adv;

  logic [10:0]       hm;
  logic [16:0]       biased;
  logic [23:0]       day_prod;
  logic [5:0]        ddays_b;
  logic [16:0]       rem_full;
  logic [10:0]       rem;
  logic [19:0]       hour_prod;
  logic [4:0]        hour_new;
  logic [5:0]        minute_new;
  logic              leap;
  logic [4:0]        cur_len;
  logic [4:0]        prev_len;
  logic [3:0]        prev_month;
  logic signed [7:0] day_sum;
  logic              in_ok;

  cmoa_pkg::out_t    res_next;
  cmoa_pkg::status_t stat_next;

  assign stage_adv = !res_valid || m_tready;
  assign s_tready  = !in_valid || stage_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_q <= cmoa_pkg::in_t'(s_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stage_adv) begin
      res_valid <= in_valid;
    end
    if (stage_adv && in_valid) begin
      res_q  <= res_next;
      stat_q <= stat_next;
    end
  end

  // Biased minute total stays positive, so floor division becomes plain division.
  assign hm        = 11'(in_q.hour_in) * 11'(cmoa_pkg::MinPerHour) + 11'(in_q.minute_in);
  assign biased    = 17'(hm) + {in_q.offset_minutes[15], in_q.offset_minutes} + Bias;
  // Divide by 1440 as a shift by 5 and a reciprocal multiply for 45.
  assign day_prod  = 24'(biased[16:5]) * 24'd2913;
  assign ddays_b   = day_prod[22:17];
  assign rem_full  = biased - 17'(ddays_b) * 17'(cmoa_pkg::MinPerDay);
  assign rem       = rem_full[10:0];
  // Divide by 60 as a shift by 2 and a reciprocal multiply for 15.
  assign hour_prod = 20'(rem[10:2]) * 20'd1093;
  assign hour_new  = hour_prod[18:14];
  assign minute_new = 6'(rem - 11'(hour_new) * 11'(cmoa_pkg::MinPerHour));

  assign leap       = (in_q.year_in[1:0] == 2'b00);
  assign cur_len    = cmoa_pkg::month_len(in_q.month_in, leap);
  assign prev_month = (in_q.month_in == 4'd1) ? 4'(cmoa_pkg::MonthPerYear)
                                              : in_q.month_in - 4'd1;
  assign prev_len   = cmoa_pkg::month_len(prev_month, leap);
  assign day_sum    = $signed(8'(in_q.day_in) + 8'(ddays_b) - 8'(cmoa_pkg::MaxDayShift));

  assign in_ok = (in_q.year_in < 7'(cmoa_pkg::YearSpan)) && (in_q.month_in != 4'd0) &&
                 (in_q.month_in <= 4'(cmoa_pkg::MonthPerYear)) &&
                 (in_q.hour_in < 5'(cmoa_pkg::HourPerDay)) &&
                 (in_q.minute_in < 6'(cmoa_pkg::MinPerHour)) &&
                 (in_q.day_in != 5'd0) && (in_q.day_in <= cur_len);

  always_comb begin
    res_next            = '0;
    res_next.millis_out = in_q.millis_in;
    res_next.second_out = in_q.second_in;
    res_next.minute_out = minute_new;
    res_next.hour_out   = hour_new;
    res_next.day_out    = day_sum[4:0];
    res_next.month_out  = in_q.month_in;
    res_next.year_out   = in_q.year_in;
    stat_next           = cmoa_pkg::STATUS_OK;
    if (!in_ok) begin
      res_next.minute_out = in_q.minute_in;
      res_next.hour_out   = in_q.hour_in;
      res_next.day_out    = in_q.day_in;
      stat_next           = cmoa_pkg::STATUS_INVALID;
    end else if (day_sum > $signed({3'b000, cur_len})) begin
      res_next.day_out = 5'(day_sum - $signed({3'b000, cur_len}));
      if (in_q.month_in == 4'(cmoa_pkg::MonthPerYear)) begin
        res_next.month_out = 4'd1;
        if (in_q.year_in == 7'(cmoa_pkg::YearSpan - 1)) begin
          res_next.year_out = 7'd0;
          stat_next         = cmoa_pkg::STATUS_WRAP;
        end else begin
          res_next.year_out = in_q.year_in + 7'd1;
        end
      end else begin
        res_next.month_out = in_q.month_in + 4'd1;
      end
    end else if (day_sum < 8'sd1) begin
      res_next.day_out   = 5'(day_sum + $signed({3'b000, prev_len}));
      res_next.month_out = prev_month;
      if (in_q.month_in == 4'd1) begin
        if (in_q.year_in == 7'd0) begin
          res_next.year_out = 7'(cmoa_pkg::YearSpan - 1);
          stat_next         = cmoa_pkg::STATUS_WRAP;
        end else begin
          res_next.year_out = in_q.year_in - 7'd1;
        end
      end
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = res_q;
  assign m_tuser  = stat_q;

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled while the result register is empty.");

  a_ok_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != cmoa_pkg::STATUS_INVALID) |->
    (res_q.month_out >= 4'd1 && res_q.month_out <= 4'd12 && res_q.hour_out < 5'd24 &&
     res_q.minute_out < 6'd60 && res_q.day_out >= 5'd1 && res_q.year_out < 7'd100))
    else $error("Adjusted date-time field out of range.");

  a_wrap_at_year_edge: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == cmoa_pkg::STATUS_WRAP) |->
    ((res_q.year_out == 7'd0 && res_q.month_out == 4'd1) ||
     (res_q.year_out == 7'd99 && res_q.month_out == 4'd12)))
    else $error("Year wrap flagged away from a year boundary.");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && stage_adv) |=> m_tvalid)
    else $error("Item in the input register was lost.");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the calendar minute offset adder.
`timescale 1ns / 1ps

module testbench;

  localparam int BaseYear = 2000;
  localparam int LongHold = 300;
  localparam int IdleLimit = 4000;

  typedef struct packed {
    cmoa_pkg::out_t    data;
    cmoa_pkg::status_t status;
  } shifted_t;

  typedef enum int {
    SinkAlways,
    SinkRandom,
    SinkBursty
  } sink_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  shifted_t    pending_times[$];
  int          mismatch_count = 0;
  int          result_count = 0;
  int          idle_cycles = 0;
  int          source_gap_max = 0;
  int          burst_left = 0;
  sink_style_t sink_style = SinkAlways;
  bit          hold_request = 1'b0;

  calendar_minute_offset_adder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int days_in_month(input int month, input int yr);
    int  full_year;
    bit  leap;
    full_year = BaseYear + yr;
    leap = (full_year % 400 == 0) || ((full_year % 4 == 0) && (full_year % 100 != 0));
    case (month)
      2: begin
        return leap ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  function automatic shifted_t shift_datetime(input cmoa_pkg::in_t item);
    shifted_t res;
    int yr;
    int mon;
    int dd;
    int hh;
    int mm;
    int total;
    int day_shift;
    int minute_of_day;
    yr = item.year_in;
    mon = item.month_in;
    dd = item.day_in;
    hh = item.hour_in;
    mm = item.minute_in;
    res = '0;
    res.data.second_out = item.second_in;
    res.data.millis_out = item.millis_in;
    res.status = cmoa_pkg::STATUS_OK;
    if (yr >= cmoa_pkg::YearSpan || mon < 1 || mon > cmoa_pkg::MonthPerYear ||
        hh >= cmoa_pkg::HourPerDay || mm >= cmoa_pkg::MinPerHour || dd < 1 ||
        dd > days_in_month(mon, yr)) begin
      res.data.year_out = item.year_in;
      res.data.month_out = item.month_in;
      res.data.day_out = item.day_in;
      res.data.hour_out = item.hour_in;
      res.data.minute_out = item.minute_in;
      res.status = cmoa_pkg::STATUS_INVALID;
      return res;
    end
    total = hh * cmoa_pkg::MinPerHour + mm + int'(item.offset_minutes);
    day_shift = total / cmoa_pkg::MinPerDay;
    minute_of_day = total % cmoa_pkg::MinPerDay;
    if (minute_of_day < 0) begin
      minute_of_day += cmoa_pkg::MinPerDay;
      day_shift -= 1;
    end
    hh = minute_of_day / cmoa_pkg::MinPerHour;
    mm = minute_of_day % cmoa_pkg::MinPerHour;
    dd += day_shift;
    if (dd > days_in_month(mon, yr)) begin
      dd -= days_in_month(mon, yr);
      mon += 1;
      if (mon > cmoa_pkg::MonthPerYear) begin
        mon = 1;
        yr += 1;
      end
    end else if (dd < 1) begin
      mon -= 1;
      if (mon < 1) begin
        mon = cmoa_pkg::MonthPerYear;
        yr -= 1;
      end
      dd += days_in_month(mon, yr);
    end
    if (yr < 0) begin
      yr += cmoa_pkg::YearSpan;
      res.status = cmoa_pkg::STATUS_WRAP;
    end else if (yr >= cmoa_pkg::YearSpan) begin
      yr -= cmoa_pkg::YearSpan;
      res.status = cmoa_pkg::STATUS_WRAP;
    end
    res.data.year_out = 7'(yr);
    res.data.month_out = 4'(mon);
    res.data.day_out = 5'(dd);
    res.data.hour_out = 5'(hh);
    res.data.minute_out = 6'(mm);
    return res;
  endfunction

  function automatic cmoa_pkg::in_t make_item(input int yr, input int mon, input int dd,
                                              input int hh, input int mm, input int ss,
                                              input int ms, input int off);
    cmoa_pkg::in_t item;
    item = '0;
    item.year_in = 7'(yr);
    item.month_in = 4'(mon);
    item.day_in = 5'(dd);
    item.hour_in = 5'(hh);
    item.minute_in = 6'(mm);
    item.second_in = 6'(ss);
    item.millis_in = 10'(ms);
    item.offset_minutes = 16'(off);
    return item;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                result_count, name, got, want));
    end
  endtask

  always @(posedge clk) begin : result_check
    cmoa_pkg::out_t got;
    shifted_t       want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_times.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                  result_count));
      end else begin
        want = pending_times.pop_front();
        check_field("year", got.year_out, want.data.year_out);
        check_field("month", got.month_out, want.data.month_out);
        check_field("day", got.day_out, want.data.day_out);
        check_field("hour", got.hour_out, want.data.hour_out);
        check_field("minute", got.minute_out, want.data.minute_out);
        check_field("second", got.second_out, want.data.second_out);
        check_field("millis", got.millis_out, want.data.millis_out);
        check_field("zero fill", got.pad, 0);
        check_field("status", m_tuser, want.status);
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : sink_driver
    int hold_left;
    int run_left;
    bit run_ready;
    hold_left = 0;
    run_left = 0;
    run_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = LongHold;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (sink_style)
          SinkAlways: begin
            m_tready <= 1'b1;
          end
          SinkRandom: begin
            m_tready <= ($urandom_range(0, 2) != 0);
          end
          default: begin
            if (run_left == 0) begin
              run_ready = !run_ready;
              run_left = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            run_left--;
            m_tready <= run_ready;
          end
        endcase
      end
    end
  end

  task automatic send_item(input cmoa_pkg::in_t item);
    int gap;
    if (source_gap_max > 0 && burst_left == 0) begin
      gap = $urandom_range(1, source_gap_max);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata <= item;
    do @(posedge clk); while (!s_tready);
    pending_times.push_back(shift_datetime(item));
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_times.size() != 0);
  endtask

  function automatic cmoa_pkg::in_t random_valid_item();
    int yr;
    int mon;
    int dd;
    int len;
    int off;
    yr = $urandom_range(0, 99);
    mon = $urandom_range(1, cmoa_pkg::MonthPerYear);
    if ($urandom_range(0, 7) == 0) begin
      yr = $urandom_range(0, 1) ? 0 : 99;
      mon = (yr == 0) ? 1 : cmoa_pkg::MonthPerYear;
    end
    len = days_in_month(mon, yr);
    case ($urandom_range(0, 3))
      0: dd = 1;
      1: dd = len;
      default: dd = $urandom_range(1, len);
    endcase
    case ($urandom_range(0, 3))
      0: off = int'($urandom_range(0, 3000)) - 1500;
      1: off = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 200))
                                    : -32768 + int'($urandom_range(0, 200));
      default: off = $urandom_range(0, 65535);
    endcase
    return make_item(yr, mon, dd, $urandom_range(0, 23), $urandom_range(0, 59),
                     $urandom_range(0, 63), $urandom_range(0, 1023), off);
  endfunction

  task automatic test_calendar_edges();
    source_gap_max = 3;
    sink_style = SinkRandom;
    send_item(make_item(0, 1, 1, 0, 0, 0, 0, 0));
    send_item(make_item(99, 12, 31, 23, 59, 59, 999, 0));
    send_item(make_item(0, 1, 1, 0, 0, 0, 0, -1));
    send_item(make_item(99, 12, 31, 23, 59, 0, 0, 1));
    send_item(make_item(50, 6, 15, 12, 30, 63, 1023, 32767));
    send_item(make_item(50, 6, 15, 12, 30, 0, 0, -32768));
    send_item(make_item(24, 2, 28, 0, 0, 1, 1, cmoa_pkg::MinPerDay));
    send_item(make_item(24, 3, 1, 0, 0, 2, 2, -1));
    send_item(make_item(23, 3, 1, 0, 0, 3, 3, -1));
    send_item(make_item(0, 2, 29, 12, 0, 4, 4, 0));
    send_item(make_item(0, 2, 29, 12, 0, 5, 5, cmoa_pkg::MinPerDay));
    send_item(make_item(10, 1, 31, 23, 59, 6, 6, 32767));
    send_item(make_item(10, 3, 1, 0, 0, 7, 7, -32768));
    send_item(make_item(99, 12, 20, 0, 0, 8, 8, 32767));
    send_item(make_item(0, 1, 5, 0, 0, 9, 9, -32768));
  endtask

  task automatic test_invalid_passthrough();
    send_item(make_item(100, 5, 5, 5, 5, 5, 5, 100));
    send_item(make_item(127, 15, 31, 31, 63, 63, 1023, -1));
    send_item(make_item(20, 0, 10, 10, 10, 10, 10, 60));
    send_item(make_item(20, 13, 10, 10, 10, 10, 10, 60));
    send_item(make_item(20, 15, 10, 10, 10, 10, 10, 60));
    send_item(make_item(20, 5, 0, 10, 10, 10, 10, 60));
    send_item(make_item(20, 4, 31, 10, 10, 10, 10, 60));
    send_item(make_item(1, 2, 29, 10, 10, 10, 10, 60));
    send_item(make_item(20, 5, 10, 24, 10, 10, 10, 60));
    send_item(make_item(20, 5, 10, 31, 10, 10, 10, 60));
    send_item(make_item(20, 5, 10, 10, 60, 10, 10, 60));
    send_item(make_item(20, 5, 10, 10, 63, 10, 10, -32768));
  endtask

  task automatic test_random_shifts(input int count, input int gap_max,
                                    input sink_style_t style);
    source_gap_max = gap_max;
    sink_style = style;
    repeat (count) send_item(random_valid_item());
  endtask

  task automatic test_random_noise(input int count);
    cmoa_pkg::in_t item;
    source_gap_max = 8;
    sink_style = SinkBursty;
    repeat (count) begin
      item = {$urandom, $urandom};
      item.pad = '0;
      if ($urandom_range(0, 1) == 0) begin
        item = random_valid_item();
      end
      send_item(item);
    end
  endtask

  task automatic test_stalled_output();
    source_gap_max = 0;
    burst_left = 0;
    hold_request = 1'b1;
    repeat (40) send_item(random_valid_item());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_calendar_edges();
    test_invalid_passthrough();
    wait_for_results();
    test_random_shifts(250, 12, SinkRandom);
    test_stalled_output();
    test_random_shifts(150, 0, SinkAlways);
    wait_for_results();
    test_random_noise(150);
    test_random_shifts(120, 20, SinkBursty);
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
